/* rtl/snsc_pkg.sv */
package snsc_pkg;

   localparam int STRIP_BITS    = 12;
   localparam int E_BITS        = 24;
   localparam int POS_BITS      = 24;
   localparam int TIME_BITS     = 16;
   localparam int ESUM_BITS     = 30;
   localparam int WSUM_BITS     = POS_BITS + ESUM_BITS;
   localparam int PROD_BITS     = POS_BITS + E_BITS + 1;
   localparam int ACC_BITS      = 64;
   localparam int CNT_BITS      = 7;
   localparam int MAX_CELLS_DEF = 64;
   localparam int MAX_RESULTS   = 64;

   localparam logic [CNT_BITS-1:0] CLUSTER_SIZE_RST = 7'd3;

   typedef struct packed {
      logic signed [STRIP_BITS-1:0] strip_y;
      logic signed [STRIP_BITS-1:0] strip_z;
      logic [E_BITS-1:0]            hit_energy;
      logic signed [POS_BITS-1:0]   hit_pos_x;
      logic signed [POS_BITS-1:0]   hit_pos_y;
      logic signed [POS_BITS-1:0]   hit_pos_z;
      logic [TIME_BITS-1:0]         hit_time;
      logic                         window_last;
   } req_type;

   typedef struct packed {
      logic signed [STRIP_BITS-1:0] seed_y;
      logic signed [STRIP_BITS-1:0] seed_z;
      logic [ESUM_BITS-1:0]         cluster_energy;
      logic signed [POS_BITS-1:0]   centroid_x;
      logic signed [POS_BITS-1:0]   centroid_y;
      logic signed [POS_BITS-1:0]   centroid_z;
      logic [TIME_BITS-1:0]         earliest_time;
      logic [CNT_BITS-1:0]          distinct_y_count;
      logic [CNT_BITS-1:0]          distinct_z_count;
      logic [CNT_BITS-1:0]          member_count;
      logic                         cell_overflow;
      logic                         last_cluster;
   } rsp_type;

   typedef struct packed {
      logic signed [STRIP_BITS-1:0] y;
      logic signed [STRIP_BITS-1:0] z;
      logic [ESUM_BITS-1:0]         e;
      logic signed [WSUM_BITS-1:0]  wx;
      logic signed [WSUM_BITS-1:0]  wy;
      logic signed [WSUM_BITS-1:0]  wz;
      logic signed [POS_BITS-1:0]   fx;
      logic signed [POS_BITS-1:0]   fy;
      logic signed [POS_BITS-1:0]   fz;
      logic [TIME_BITS-1:0]         t;
   } cell_rec_type;

   typedef struct packed {
      logic taken;
      logic inclu;
      logic adj;
      logic ys;
      logic zs;
   } cell_flag_type;

   typedef struct packed {
      logic                         clear;
      logic                         shift;
      logic                         load;
      logic                         bcast;
      logic                         new_cluster;
      cell_rec_type                 hit;
      logic signed [STRIP_BITS-1:0] bc_y;
      logic signed [STRIP_BITS-1:0] bc_z;
   } cell_ctrl_type;

   function automatic logic signed [WSUM_BITS-1:0] sat_wsum(
      input logic signed [WSUM_BITS-1:0] a,
      input logic signed [WSUM_BITS-1:0] b);
      logic signed [WSUM_BITS:0] s;
      s = (WSUM_BITS+1)'(a) + (WSUM_BITS+1)'(b);
      if (s[WSUM_BITS] != s[WSUM_BITS-1])
         return s[WSUM_BITS] ? {1'b1, {(WSUM_BITS-1){1'b0}}}
                             : {1'b0, {(WSUM_BITS-1){1'b1}}};
      return s[WSUM_BITS-1:0];
   endfunction

   // clamp to [-2^62, 2^62-1]
   function automatic logic signed [ACC_BITS-1:0] sat_acc(
      input logic signed [ACC_BITS-1:0]  a,
      input logic signed [WSUM_BITS-1:0] b);
      logic signed [ACC_BITS:0] s;
      s = (ACC_BITS+1)'(a) + (ACC_BITS+1)'(b);
      if (s[ACC_BITS:ACC_BITS-2] == 3'b000 || s[ACC_BITS:ACC_BITS-2] == 3'b111)
         return s[ACC_BITS-1:0];
      return s[ACC_BITS] ? {2'b11, {(ACC_BITS-2){1'b0}}}
                         : {2'b00, {(ACC_BITS-2){1'b1}}};
   endfunction

   function automatic logic near(
      input logic signed [STRIP_BITS-1:0] a,
      input logic signed [STRIP_BITS-1:0] b);
      logic signed [STRIP_BITS:0] d;
      d = (STRIP_BITS+1)'(a) - (STRIP_BITS+1)'(b);
      return d == 0 || d == 1 || d == -1;
   endfunction

endpackage

/* rtl/snsc_cell.sv */
module snsc_cell import snsc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          sel_new,
   input  logic          sel_mark,
   input  cell_rec_type  nb_rec,
   input  cell_flag_type nb_flag,
   output cell_rec_type  rec,
   output cell_flag_type flag,
   output logic          match
);

   cell_rec_type  rec_ff, rec_in;
   cell_flag_type flag_ff, flag_in;
   logic [ESUM_BITS:0] esum;

   assign rec  = rec_ff;
   assign flag = flag_ff;

   always_comb begin
      rec_in  = rec_ff;
      flag_in = flag_ff;
      match   = flag_ff.taken && rec_ff.y == ctrl.hit.y && rec_ff.z == ctrl.hit.z;
      esum    = {1'b0, rec_ff.e} + {1'b0, ctrl.hit.e};
      if (ctrl.clear) begin
         flag_in = '0;
      end else if (ctrl.shift) begin
         // advance one place toward the head
         rec_in  = nb_rec;
         flag_in = nb_flag;
      end else if (ctrl.load) begin
         if (match) begin
            rec_in.e  = esum[ESUM_BITS] ? {ESUM_BITS{1'b1}} : esum[ESUM_BITS-1:0];
            rec_in.wx = sat_wsum(rec_ff.wx, ctrl.hit.wx);
            rec_in.wy = sat_wsum(rec_ff.wy, ctrl.hit.wy);
            rec_in.wz = sat_wsum(rec_ff.wz, ctrl.hit.wz);
            if (ctrl.hit.t < rec_ff.t) rec_in.t = ctrl.hit.t;
         end else if (sel_new) begin
            rec_in        = ctrl.hit;
            flag_in       = '0;
            flag_in.taken = 1'b1;
         end
      end else if (ctrl.bcast) begin
         if (ctrl.new_cluster) begin
            flag_in.adj = 1'b0;
            flag_in.ys  = 1'b0;
            flag_in.zs  = 1'b0;
         end
         if (rec_ff.y == ctrl.bc_y) flag_in.ys = 1'b1;
         if (rec_ff.z == ctrl.bc_z) flag_in.zs = 1'b1;
         if (near(rec_ff.y, ctrl.bc_y) && near(rec_ff.z, ctrl.bc_z)
             && !(rec_ff.y == ctrl.bc_y && rec_ff.z == ctrl.bc_z))
            flag_in.adj = 1'b1;
         if (sel_mark) flag_in.inclu = 1'b1;
      end else begin
         flag_in = flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= '0;
      end else begin
         flag_ff <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule

/* rtl/snsc_div.sv */
module snsc_div import snsc_pkg::*; #(
   parameter int DVS_BITS = 36
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [ACC_BITS-1:0] dividend,
   input  logic [DVS_BITS-1:0]        divisor,
   output logic                       done,
   output logic signed [ACC_BITS-1:0] quotient
);

   localparam int CW = $clog2(ACC_BITS);

   logic                run_ff, run_in, done_ff, done_in, neg_ff, neg_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [ACC_BITS-1:0] dq_ff, dq_in;
   logic [DVS_BITS-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [DVS_BITS+1:0] diff;

   assign done     = done_ff;
   assign quotient = neg_ff ? -dq_ff : dq_ff;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      diff    = {1'b0, rem_ff, dq_ff[ACC_BITS-1]} - {2'b00, dvs_ff};
      if (start) begin
         run_in = 1'b1;
         neg_in = dividend[ACC_BITS-1];
         dq_in  = dividend[ACC_BITS-1] ? -dividend : dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = '0;
      end else if (run_ff) begin
         // one quotient bit a cycle, restoring
         if (!diff[DVS_BITS+1]) begin
            rem_in = diff[DVS_BITS-1:0];
            dq_in  = {dq_ff[ACC_BITS-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DVS_BITS-2:0], dq_ff[ACC_BITS-1]};
            dq_in  = {dq_ff[ACC_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(ACC_BITS-1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule

/* rtl/seeded_neighbour_strip_clustering.sv */
// Hit load: accept, then the product stage (ST_MUL), then the merge into the cell row.
// Clustering after the window's last hit: each seed search and each grow step is one
// full rotation of the cell row, then ST_SDEC or ST_GDEC; each member add is ST_ADD;
// each cluster then runs three serial divisions on the shared divider
// and then queues its result (ST_PEND).
// Results come one cycle each on rsp_valid; the receiver cannot stall them.
// Synchronous active-high reset empties the cell row and sets max_cluster_size to 3.
module seeded_neighbour_strip_clustering import snsc_pkg::*; #(
   parameter int MAX_CELLS = MAX_CELLS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req_data,
   output logic                rsp_valid,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CNT_BITS-1:0] csr_data
);

   localparam int CW = $clog2(MAX_CELLS + 1);
   localparam int IW = $clog2(MAX_CELLS);
   localparam int EW = ESUM_BITS + $clog2(MAX_CELLS);
   localparam int RW = $clog2(MAX_RESULTS + 1);
   localparam int LW = (CW + 1 > CNT_BITS) ? CW + 1 : CNT_BITS;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL   = 4'd1;
   localparam logic [3:0] ST_LOAD  = 4'd2;
   localparam logic [3:0] ST_SSCAN = 4'd3;
   localparam logic [3:0] ST_SDEC  = 4'd4;
   localparam logic [3:0] ST_ADD   = 4'd5;
   localparam logic [3:0] ST_GSCAN = 4'd6;
   localparam logic [3:0] ST_GDEC  = 4'd7;
   localparam logic [3:0] ST_DIV   = 4'd8;
   localparam logic [3:0] ST_PEND  = 4'd9;

   function automatic logic [CNT_BITS-1:0] sat_cnt(input logic [CW-1:0] v);
      return (32'(v) > 127) ? 7'd127 : CNT_BITS'(v);
   endfunction

   function automatic logic signed [POS_BITS-1:0] sat_pos(
      input logic signed [ACC_BITS-1:0] q);
      logic [ACC_BITS-POS_BITS:0] top;
      top = q[ACC_BITS-1:POS_BITS-1];
      if (top == '0 || top == '1) return q[POS_BITS-1:0];
      return q[ACC_BITS-1] ? {1'b1, {(POS_BITS-1){1'b0}}}
                           : {1'b0, {(POS_BITS-1){1'b1}}};
   endfunction

   // control state
   logic [3:0]           state_ff, state_in;
   logic [CW-1:0]        filled_ff, filled_in;
   logic                 ovf_ff, ovf_in;
   logic [CNT_BITS-1:0]  maxsz_ff, maxsz_in;
   logic [IW-1:0]        scan_ff, scan_in;
   logic                 found_ff, found_in;
   logic                 seed_ff, seed_in;
   logic [1:0]           dsel_ff, dsel_in;
   logic                 dgo_ff, dgo_in;
   logic                 pendv_ff, pendv_in;
   logic [RW-1:0]        nres_ff, nres_in;
   logic                 rspv_ff, rspv_in;

   // payload
   req_type              hit_ff, hit_in;
   logic signed [PROD_BITS-1:0] px_ff, py_ff, pz_ff;
   logic [IW-1:0]        bidx_ff, bidx_in;
   cell_rec_type         best_ff, best_in, seedr_ff, seedr_in;
   logic [CW-1:0]        bny_ff, bny_in, bnz_ff, bnz_in;
   logic [EW-1:0]        esum_ff, esum_in;
   logic signed [ACC_BITS-1:0] wx_ff, wx_in, wy_ff, wy_in, wz_ff, wz_in;
   logic [TIME_BITS-1:0] tmin_ff, tmin_in;
   logic [CW-1:0]        dy_ff, dy_in, dz_ff, dz_in, m_ff, m_in;
   logic signed [POS_BITS-1:0] q_ff [3];
   logic signed [POS_BITS-1:0] q_in [3];
   rsp_type              pend_ff, pend_in, rsp_ff, rsp_in, clu_rsp;

   // cell row
   cell_ctrl_type        ctrl;
   cell_rec_type         crec  [MAX_CELLS];
   cell_flag_type        cflag [MAX_CELLS];
   logic [MAX_CELLS-1:0] cmatch, sel_new, sel_mark;
   logic                 any_match, room, clear_now;

   // head of the row and divider
   logic [CW:0]          head_ny, head_nz;
   logic                 head_take;
   logic                 div_done;
   logic signed [ACC_BITS-1:0] div_q, div_a;

   assign busy      = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

   assign any_match = |cmatch;
   assign room      = filled_ff < CW'(MAX_CELLS);

   always_comb begin
      ctrl             = '0;
      ctrl.clear       = clear_now;
      ctrl.shift       = state_ff == ST_SSCAN || state_ff == ST_GSCAN;
      ctrl.load        = state_ff == ST_LOAD;
      ctrl.bcast       = state_ff == ST_ADD;
      ctrl.new_cluster = seed_ff;
      ctrl.hit.y       = hit_ff.strip_y;
      ctrl.hit.z       = hit_ff.strip_z;
      ctrl.hit.e       = ESUM_BITS'(hit_ff.hit_energy);
      ctrl.hit.wx      = WSUM_BITS'(px_ff);
      ctrl.hit.wy      = WSUM_BITS'(py_ff);
      ctrl.hit.wz      = WSUM_BITS'(pz_ff);
      ctrl.hit.fx      = hit_ff.hit_pos_x;
      ctrl.hit.fy      = hit_ff.hit_pos_y;
      ctrl.hit.fz      = hit_ff.hit_pos_z;
      ctrl.hit.t       = hit_ff.hit_time;
      ctrl.bc_y        = best_ff.y;
      ctrl.bc_z        = best_ff.z;
   end

   // cell k takes its neighbor k+1 on a shift; the head wraps to the tail, so a
   // full rotation brings every cell back to its own slot
   for (genvar k = 0; k < MAX_CELLS; k++) begin : g_cell
      assign sel_new[k]  = !any_match && room && filled_ff == CW'(k);
      assign sel_mark[k] = bidx_ff == IW'(k);
      snsc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .sel_new (sel_new[k]),
         .sel_mark(sel_mark[k]),
         .nb_rec  (crec[(k + 1) % MAX_CELLS]),
         .nb_flag (cflag[(k + 1) % MAX_CELLS]),
         .rec     (crec[k]),
         .flag    (cflag[k]),
         .match   (cmatch[k])
      );
   end

   // head of the row: candidate test, strict greater keeps the lowest index on ties
   always_comb begin
      head_ny   = (CW+1)'(dy_ff) + (cflag[0].ys ? '0 : (CW+1)'(1));
      head_nz   = (CW+1)'(dz_ff) + (cflag[0].zs ? '0 : (CW+1)'(1));
      head_take = cflag[0].taken && !cflag[0].inclu
                  && (!found_ff || crec[0].e > best_ff.e)
                  && (state_ff == ST_SSCAN
                      || (cflag[0].adj && LW'(head_ny) <= LW'(maxsz_ff)
                          && LW'(head_nz) <= LW'(maxsz_ff)));
   end

   always_comb begin
      unique case (dsel_ff)
         2'd0:    div_a = wx_ff;
         2'd1:    div_a = wy_ff;
         default: div_a = wz_ff;
      endcase
   end

   snsc_div #(.DVS_BITS(EW)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (dgo_ff),
      .dividend(div_a),
      .divisor (esum_ff),
      .done    (div_done),
      .quotient(div_q)
   );

   // finished cluster, centroid falls back to the seed's first position at zero energy
   always_comb begin
      clu_rsp                  = '0;
      clu_rsp.seed_y           = seedr_ff.y;
      clu_rsp.seed_z           = seedr_ff.z;
      clu_rsp.cluster_energy   = (esum_ff >> ESUM_BITS) != '0 ? {ESUM_BITS{1'b1}}
                                                              : esum_ff[ESUM_BITS-1:0];
      clu_rsp.centroid_x       = esum_ff == '0 ? seedr_ff.fx : q_ff[0];
      clu_rsp.centroid_y       = esum_ff == '0 ? seedr_ff.fy : q_ff[1];
      clu_rsp.centroid_z       = esum_ff == '0 ? seedr_ff.fz : q_ff[2];
      clu_rsp.earliest_time    = tmin_ff;
      clu_rsp.distinct_y_count = sat_cnt(dy_ff);
      clu_rsp.distinct_z_count = sat_cnt(dz_ff);
      clu_rsp.member_count     = sat_cnt(m_ff);
      clu_rsp.cell_overflow    = ovf_ff;
   end

   always_comb begin
      state_in  = state_ff;
      filled_in = filled_ff;
      ovf_in    = ovf_ff;
      maxsz_in  = csr_valid ? csr_data : maxsz_ff;
      scan_in   = scan_ff;
      found_in  = found_ff;
      seed_in   = seed_ff;
      dsel_in   = dsel_ff;
      dgo_in    = 1'b0;
      pendv_in  = pendv_ff;
      nres_in   = nres_ff;
      rspv_in   = 1'b0;
      rsp_in    = rsp_ff;
      hit_in    = hit_ff;
      bidx_in   = bidx_ff;
      best_in   = best_ff;
      bny_in    = bny_ff;
      bnz_in    = bnz_ff;
      seedr_in  = seedr_ff;
      esum_in   = esum_ff;
      wx_in     = wx_ff;
      wy_in     = wy_ff;
      wz_in     = wz_ff;
      tmin_in   = tmin_ff;
      dy_in     = dy_ff;
      dz_in     = dz_ff;
      m_in      = m_ff;
      q_in      = q_ff;
      pend_in   = pend_ff;
      clear_now = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               hit_in   = req_data;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            // merge into a held cell, else open a new one, else drop and flag
            if (!any_match) begin
               if (room) filled_in = filled_ff + 1'b1;
               else      ovf_in    = 1'b1;
            end
            if (hit_ff.window_last) begin
               state_in = ST_SSCAN;
               scan_in  = '0;
               found_in = 1'b0;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SSCAN, ST_GSCAN: begin
            if (head_take) begin
               found_in = 1'b1;
               bidx_in  = scan_ff;
               best_in  = crec[0];
               bny_in   = CW'(head_ny);
               bnz_in   = CW'(head_nz);
            end
            scan_in = scan_ff + 1'b1;
            if (scan_ff == IW'(MAX_CELLS - 1)) begin
               scan_in  = '0;
               state_in = (state_ff == ST_SSCAN) ? ST_SDEC : ST_GDEC;
            end
         end
         ST_SDEC: begin
            // hold the previous cluster until we know whether another follows
            if (pendv_ff) begin
               rspv_in             = 1'b1;
               rsp_in              = pend_ff;
               rsp_in.last_cluster = !found_ff;
               pendv_in            = 1'b0;
            end
            if (found_ff) begin
               seed_in  = 1'b1;
               state_in = ST_ADD;
            end else begin
               clear_now = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_ADD: begin
            if (seed_ff) begin
               esum_in  = EW'(best_ff.e);
               wx_in    = ACC_BITS'(best_ff.wx);
               wy_in    = ACC_BITS'(best_ff.wy);
               wz_in    = ACC_BITS'(best_ff.wz);
               tmin_in  = best_ff.t;
               seedr_in = best_ff;
               dy_in    = CW'(1);
               dz_in    = CW'(1);
               m_in     = CW'(1);
            end else begin
               esum_in = esum_ff + EW'(best_ff.e);
               wx_in   = sat_acc(wx_ff, best_ff.wx);
               wy_in   = sat_acc(wy_ff, best_ff.wy);
               wz_in   = sat_acc(wz_ff, best_ff.wz);
               if (best_ff.t < tmin_ff) tmin_in = best_ff.t;
               dy_in = bny_ff;
               dz_in = bnz_ff;
               m_in  = m_ff + 1'b1;
            end
            seed_in  = 1'b0;
            found_in = 1'b0;
            scan_in  = '0;
            state_in = ST_GSCAN;
         end
         ST_GDEC: begin
            if (found_ff) begin
               state_in = ST_ADD;
            end else begin
               dsel_in  = 2'd0;
               dgo_in   = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               q_in[dsel_ff] = sat_pos(div_q);
               if (dsel_ff == 2'd2) begin
                  state_in = ST_PEND;
               end else begin
                  dsel_in = dsel_ff + 1'b1;
                  dgo_in  = 1'b1;
               end
            end
         end
         ST_PEND: begin
            nres_in = nres_ff + 1'b1;
            if (nres_ff + 1'b1 == RW'(MAX_RESULTS)) begin
               rspv_in             = 1'b1;
               rsp_in              = clu_rsp;
               rsp_in.last_cluster = 1'b1;
               clear_now           = 1'b1;
               state_in            = ST_IDLE;
            end else begin
               pend_in  = clu_rsp;
               pendv_in = 1'b1;
               found_in = 1'b0;
               scan_in  = '0;
               state_in = ST_SSCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // drop the window once its last result is out
      if (clear_now) begin
         filled_in = '0;
         ovf_in    = 1'b0;
         nres_in   = '0;
         pendv_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         filled_ff <= '0;
         ovf_ff    <= 1'b0;
         maxsz_ff  <= CLUSTER_SIZE_RST;
         scan_ff   <= '0;
         found_ff  <= 1'b0;
         seed_ff   <= 1'b0;
         dsel_ff   <= '0;
         dgo_ff    <= 1'b0;
         pendv_ff  <= 1'b0;
         nres_ff   <= '0;
         rspv_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         filled_ff <= filled_in;
         ovf_ff    <= ovf_in;
         maxsz_ff  <= maxsz_in;
         scan_ff   <= scan_in;
         found_ff  <= found_in;
         seed_ff   <= seed_in;
         dsel_ff   <= dsel_in;
         dgo_ff    <= dgo_in;
         pendv_ff  <= pendv_in;
         nres_ff   <= nres_in;
         rspv_ff   <= rspv_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff   <= hit_in;
      px_ff    <= hit_ff.hit_pos_x * $signed({1'b0, hit_ff.hit_energy});
      py_ff    <= hit_ff.hit_pos_y * $signed({1'b0, hit_ff.hit_energy});
      pz_ff    <= hit_ff.hit_pos_z * $signed({1'b0, hit_ff.hit_energy});
      bidx_ff  <= bidx_in;
      best_ff  <= best_in;
      bny_ff   <= bny_in;
      bnz_ff   <= bnz_in;
      seedr_ff <= seedr_in;
      esum_ff  <= esum_in;
      wx_ff    <= wx_in;
      wy_ff    <= wy_in;
      wz_ff    <= wz_in;
      tmin_ff  <= tmin_in;
      dy_ff    <= dy_in;
      dz_ff    <= dz_in;
      m_ff     <= m_in;
      q_ff     <= q_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

endmodule

/* rtl/snsc_chk.sv */
module snsc_chk import snsc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transfer did not make the block busy");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_cluster |-> busy)
      else $error("non-final result while idle");

   a_members: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.member_count != '0
                    && rsp_data.distinct_y_count <= rsp_data.member_count
                    && rsp_data.distinct_z_count <= rsp_data.member_count)
      else $error("cluster sizes inconsistent");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_cluster |=> !rsp_valid)
      else $error("result after final cluster");

endmodule

bind seeded_neighbour_strip_clustering snsc_chk u_snsc_chk (.*);

/* test/snsc_checker.sv */
`timescale 1ns / 100ps

module snsc_checker import snsc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  req_type             req_data,
   input  logic                rsp_valid,
   input  rsp_type             rsp_data,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [CNT_BITS-1:0] csr_data,
   output int                  fail_count,
   output int                  pending
);

   localparam int     STORE_DEPTH = MAX_CELLS_DEF;
   localparam longint ESUM_CAP    = (64'sd1 <<< ESUM_BITS) - 1;
   localparam longint WSUM_LIM    = 64'sd1 <<< (WSUM_BITS - 1);
   localparam longint CLUSTER_LIM = 64'sd1 <<< 62;
   localparam longint POS_LIM     = 64'sd1 <<< (POS_BITS - 1);

   logic signed [STRIP_BITS-1:0] cell_y [STORE_DEPTH];
   logic signed [STRIP_BITS-1:0] cell_z [STORE_DEPTH];
   longint cell_e [STORE_DEPTH];
   longint cell_wx [STORE_DEPTH];
   longint cell_wy [STORE_DEPTH];
   longint cell_wz [STORE_DEPTH];
   longint cell_fx [STORE_DEPTH];
   longint cell_fy [STORE_DEPTH];
   longint cell_fz [STORE_DEPTH];
   longint cell_t [STORE_DEPTH];
   int     cells_held;
   bit     store_overflow;
   logic [CNT_BITS-1:0] size_limit;

   rsp_type cluster_q [$];
   int      mismatches = 0;

   function automatic longint clamp(longint v, longint lim);
      if (v > lim - 1) return lim - 1;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic bit touching(int a, int b);
      int dy, dz;
      dy = int'(cell_y[a]) - int'(cell_y[b]);
      dz = int'(cell_z[a]) - int'(cell_z[b]);
      if (dy < 0) dy = -dy;
      if (dz < 0) dz = -dz;
      return dy <= 1 && dz <= 1 && (dy + dz) > 0;
   endfunction

   // merge a hit into its cell, or open a new cell if the store has room
   function automatic void store_hit(req_type h);
      longint e, px, py, pz, t;
      int i;
      e  = h.hit_energy;
      px = h.hit_pos_x;
      py = h.hit_pos_y;
      pz = h.hit_pos_z;
      t  = h.hit_time;
      for (i = 0; i < cells_held; i++) begin
         if (cell_y[i] == h.strip_y && cell_z[i] == h.strip_z) begin
            cell_e[i]  = (cell_e[i] + e > ESUM_CAP) ? ESUM_CAP : cell_e[i] + e;
            cell_wx[i] = clamp(cell_wx[i] + px * e, WSUM_LIM);
            cell_wy[i] = clamp(cell_wy[i] + py * e, WSUM_LIM);
            cell_wz[i] = clamp(cell_wz[i] + pz * e, WSUM_LIM);
            if (t < cell_t[i]) cell_t[i] = t;
            return;
         end
      end
      if (cells_held >= STORE_DEPTH) begin
         store_overflow = 1'b1;
         return;
      end
      i = cells_held;
      cell_y[i]  = h.strip_y;
      cell_z[i]  = h.strip_z;
      cell_e[i]  = e;
      cell_wx[i] = px * e;
      cell_wy[i] = py * e;
      cell_wz[i] = pz * e;
      cell_fx[i] = px;
      cell_fy[i] = py;
      cell_fz[i] = pz;
      cell_t[i]  = t;
      cells_held++;
   endfunction

   function automatic longint centroid(longint wsum, longint esum, longint first);
      if (esum == 0) return first;
      return clamp(wsum / esum, POS_LIM);
   endfunction

   // seed-and-grow over the whole window, then empty the store
   function automatic void form_clusters();
      int     members [STORE_DEPTH];
      bit     used [STORE_DEPTH];
      int     seed, best, m, k, i, n_found, dy, dz, ny, nz, by, bz;
      bit     found, have, adj, ys, zs;
      longint esum, wx, wy, wz, tmin;
      rsp_type r;
      rsp_type window_q [$];
      for (i = 0; i < STORE_DEPTH; i++) used[i] = 1'b0;
      n_found = 0;
      while (n_found < MAX_RESULTS) begin
         found = 1'b0;
         seed  = 0;
         for (i = 0; i < cells_held; i++)
            if (!used[i] && (!found || cell_e[i] > cell_e[seed])) begin
               seed  = i;
               found = 1'b1;
            end
         if (!found) break;
         members[0] = seed;
         m  = 1;
         dy = 1;
         dz = 1;
         used[seed] = 1'b1;
         forever begin
            have = 1'b0;
            best = 0;
            by   = 0;
            bz   = 0;
            for (i = 0; i < cells_held; i++) begin
               if (used[i]) continue;
               adj = 1'b0;
               ys  = 1'b0;
               zs  = 1'b0;
               for (k = 0; k < m; k++) begin
                  if (touching(i, members[k])) adj = 1'b1;
                  if (cell_y[members[k]] == cell_y[i]) ys = 1'b1;
                  if (cell_z[members[k]] == cell_z[i]) zs = 1'b1;
               end
               if (!adj) continue;
               ny = ys ? dy : dy + 1;
               nz = zs ? dz : dz + 1;
               if (ny > size_limit || nz > size_limit) continue;
               if (!have || cell_e[i] > cell_e[best]) begin
                  best = i;
                  by   = ny;
                  bz   = nz;
                  have = 1'b1;
               end
            end
            if (!have) break;
            members[m++] = best;
            used[best] = 1'b1;
            dy = by;
            dz = bz;
         end
         esum = 0;
         wx   = 0;
         wy   = 0;
         wz   = 0;
         tmin = cell_t[seed];
         for (k = 0; k < m; k++) begin
            esum += cell_e[members[k]];
            wx = clamp(wx + cell_wx[members[k]], CLUSTER_LIM);
            wy = clamp(wy + cell_wy[members[k]], CLUSTER_LIM);
            wz = clamp(wz + cell_wz[members[k]], CLUSTER_LIM);
            if (cell_t[members[k]] < tmin) tmin = cell_t[members[k]];
         end
         r.seed_y           = cell_y[seed];
         r.seed_z           = cell_z[seed];
         r.cluster_energy   = ESUM_BITS'((esum > ESUM_CAP) ? ESUM_CAP : esum);
         r.centroid_x       = POS_BITS'(centroid(wx, esum, cell_fx[seed]));
         r.centroid_y       = POS_BITS'(centroid(wy, esum, cell_fy[seed]));
         r.centroid_z       = POS_BITS'(centroid(wz, esum, cell_fz[seed]));
         r.earliest_time    = TIME_BITS'(tmin);
         r.distinct_y_count = CNT_BITS'((dy > 127) ? 127 : dy);
         r.distinct_z_count = CNT_BITS'((dz > 127) ? 127 : dz);
         r.member_count     = CNT_BITS'((m > 127) ? 127 : m);
         r.cell_overflow    = store_overflow;
         r.last_cluster     = 1'b0;
         window_q = {window_q, r};
         n_found++;
      end
      if (window_q.size() > 0)
         window_q[window_q.size() - 1].last_cluster = 1'b1;
      cluster_q = {cluster_q, window_q};
      cells_held     = 0;
      store_overflow = 1'b0;
   endfunction

   function automatic void check_field(string field, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_cluster(rsp_type got);
      rsp_type want;
      if (cluster_q.size() == 0) begin
         $error("unexpected cluster transfer, seed (%0d,%0d)", got.seed_y, got.seed_z);
         mismatches++;
         return;
      end
      want = cluster_q.pop_front();
      check_field("seed_y", want.seed_y, got.seed_y);
      check_field("seed_z", want.seed_z, got.seed_z);
      check_field("cluster_energy", want.cluster_energy, got.cluster_energy);
      check_field("centroid_x", want.centroid_x, got.centroid_x);
      check_field("centroid_y", want.centroid_y, got.centroid_y);
      check_field("centroid_z", want.centroid_z, got.centroid_z);
      check_field("earliest_time", want.earliest_time, got.earliest_time);
      check_field("distinct_y_count", want.distinct_y_count, got.distinct_y_count);
      check_field("distinct_z_count", want.distinct_z_count, got.distinct_z_count);
      check_field("member_count", want.member_count, got.member_count);
      check_field("cell_overflow", want.cell_overflow, got.cell_overflow);
      check_field("last_cluster", want.last_cluster, got.last_cluster);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         size_limit     = CLUSTER_SIZE_RST;
         cells_held     = 0;
         store_overflow = 1'b0;
         cluster_q.delete();
      end else begin
         if (csr_valid && csr_ready) size_limit = csr_data;
         if (rsp_valid) check_cluster(rsp_data);
         if (start && !busy) begin
            store_hit(req_data);
            if (req_data.window_last) form_clusters();
         end
      end
      fail_count <= mismatches;
      pending    <= cluster_q.size();
   end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import snsc_pkg::*;

   // the worst windows stay far below this cycle limit
   localparam int CYCLE_LIMIT = 3000000;
   localparam int ENERGY_MAX  = 24'hFFFFFF;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_data;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [CNT_BITS-1:0] csr_data;
   int                  fail_count;
   int                  pending;
   int                  cycles = 0;
   bit                  no_gaps;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   seeded_neighbour_strip_clustering i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   snsc_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // hard stop in case the block hangs or drops clusters
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // hold the hit on the bus until the block takes it
   task automatic send_hit(req_type h);
      req_data <= h;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // drop start for a random gap: mostly none or short, now and then long
   task automatic idle_gap();
      int r, n;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 45) n = 0;
      else if (r < 90) n = $urandom_range(1, 3);
      else n = $urandom_range(10, 40);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // wait until every cluster has arrived and the block has settled
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_size_limit(logic [CNT_BITS-1:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type make_hit(int y, int z, int e, int px, int py, int pz,
                                        int t, bit last);
      req_type h;
      h.strip_y     = STRIP_BITS'(y);
      h.strip_z     = STRIP_BITS'(z);
      h.hit_energy  = E_BITS'(e);
      h.hit_pos_x   = POS_BITS'(px);
      h.hit_pos_y   = POS_BITS'(py);
      h.hit_pos_z   = POS_BITS'(pz);
      h.hit_time    = TIME_BITS'(t);
      h.window_last = last;
      return h;
   endfunction

   function automatic logic [E_BITS-1:0] rand_energy();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return E_BITS'(ENERGY_MAX);
      if (r < 40) return E_BITS'($urandom_range(1, 15));
      return E_BITS'($urandom);
   endfunction

   function automatic logic [POS_BITS-1:0] rand_pos();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return {1'b1, {(POS_BITS-1){1'b0}}};
      if (r < 20) return {1'b0, {(POS_BITS-1){1'b1}}};
      return POS_BITS'($urandom);
   endfunction

   // one window of n hits: compact patch, scattered noise, dense grid
   // (fills the store past capacity) or one cell hit again and again
   task automatic run_window(int n, int shape);
      req_type h;
      int base_y, base_z, k;
      base_y = $urandom_range(0, 4095) - 2048;
      base_z = $urandom_range(0, 4095) - 2048;
      no_gaps = ($urandom_range(0, 3) == 0);
      for (k = 0; k < n; k++) begin
         h.hit_energy = rand_energy();
         h.hit_pos_x  = rand_pos();
         h.hit_pos_y  = rand_pos();
         h.hit_pos_z  = rand_pos();
         h.hit_time   = TIME_BITS'($urandom_range(0, 65535));
         case (shape)
            0: begin
               h.strip_y = STRIP_BITS'(base_y + $urandom_range(0, 3));
               h.strip_z = STRIP_BITS'(base_z + $urandom_range(0, 3));
            end
            1: begin
               h.strip_y = STRIP_BITS'($urandom);
               h.strip_z = STRIP_BITS'($urandom);
            end
            2: begin
               h.strip_y = STRIP_BITS'(base_y + k % 9);
               h.strip_z = STRIP_BITS'(base_z + k / 9);
            end
            default: begin
               h.strip_y    = STRIP_BITS'(base_y);
               h.strip_z    = STRIP_BITS'(base_z);
               h.hit_energy = E_BITS'(ENERGY_MAX);
               h.hit_pos_x  = {1'b0, {(POS_BITS-1){1'b1}}};
               h.hit_pos_y  = {1'b1, {(POS_BITS-1){1'b0}}};
            end
         endcase
         h.window_last = (k == n - 1);
         send_hit(h);
         idle_gap();
      end
   endtask

   initial begin
      int phase_sizes [6];
      int n, p;
      phase_sizes = '{64, 1, 0, 127, 3, 0};
      phase_sizes[5] = $urandom_range(1, 64);
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      no_gaps   = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // field extremes, lone zero-energy cell, merging, ties, and adjacency
      // that must not wrap across the strip range
      send_hit(make_hit(-2048, 2047, ENERGY_MAX, -8388608, -8388608, -8388608,
                        65535, 1'b1));
      send_hit(make_hit(5, -7, 0, 8388607, 8388607, 8388607, 0, 1'b1));
      idle_gap();
      send_hit(make_hit(0, 0, 100, 1600, -320, 48, 900, 1'b0));
      send_hit(make_hit(0, 0, 50, 1700, -300, 40, 400, 1'b0));
      idle_gap();
      send_hit(make_hit(1, 1, 150, 1800, -200, 64, 700, 1'b0));
      send_hit(make_hit(2, 0, 30, 1900, -100, 80, 650, 1'b0));
      send_hit(make_hit(5, 5, 150, 2500, 100, 120, 30, 1'b0));
      send_hit(make_hit(-1, -1, 0, 1500, -400, 16, 10, 1'b0));
      send_hit(make_hit(1, 0, 7, 1650, -250, 32, 800, 1'b1));
      send_hit(make_hit(2047, 2047, 20, 100, 100, 100, 5, 1'b0));
      send_hit(make_hit(-2048, 2047, 20, -100, -100, -100, 6, 1'b0));
      send_hit(make_hit(2046, 2047, 0, 0, 0, 0, 7, 1'b0));
      send_hit(make_hit(-2048, -2048, 0, 0, 0, 0, 8, 1'b1));
      idle_gap();
      send_hit(make_hit(3, 3, 0, -5, 6, -7, 100, 1'b0));
      send_hit(make_hit(4, 4, 0, 9, -9, 9, 50, 1'b1));
      // pause until every cluster is back before touching the size limit
      drain();

      for (p = 0; p < 6; p++) begin
         write_size_limit(CNT_BITS'(phase_sizes[p]));
         n = $urandom_range(1, 5);
         run_window(n, ($urandom_range(0, 9) < 7) ? 0 : 1);
         if (p == 1) run_window(68, 2);
         if (p == 4) run_window(66, 3);
         drain();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
